/* rtl/qegt_pkg.sv */
// Quadrature encoder gain tuner: shared types and constants.
// Used by the channel interfaces and the core; depends on nothing.
package qegt_pkg;

  localparam int EncBits     = 2;
  localparam int AxisBits    = 2;
  localparam int IndexBits   = 4;
  localparam int ValueBits   = 16;
  localparam int StepBits    = 8;
  localparam int CodeBits    = 4;
  localparam int HistBits    = 8;
  localparam int NumGains    = 9;
  localparam int TermsPerAxis = 3;
  localparam int GainEncoders = 3;
  localparam int NumAxes     = 3;
  localparam int CfgIdxBits  = 1;

  localparam logic [15:0]         VALID_MASK = 16'h6996;
  localparam logic [HistBits-1:0] HIST_DOWN  = 8'h2b;
  localparam logic [HistBits-1:0] HIST_UP    = 8'h17;

  localparam logic [EncBits-1:0]    ENC_COARSE      = 2'd2;
  localparam logic [CfgIdxBits-1:0] CFG_FINE_STEP   = 1'd0;
  localparam logic [CfgIdxBits-1:0] CFG_COARSE_STEP = 1'd1;

  typedef enum logic [1:0] {
    MOV_NONE = 2'd0,
    MOV_UP   = 2'd1,
    MOV_DOWN = 2'd2
  } movement_e;

  typedef struct packed {
    logic [EncBits-1:0]  encoder;
    logic                level_a;
    logic                level_b;
    logic [AxisBits-1:0] axis;
  } item_t;

  typedef struct packed {
    movement_e            movement;
    logic [IndexBits-1:0] gain_index;
    logic [ValueBits-1:0] gain_value;
  } result_t;

endpackage

/* rtl/qegt_if.sv */
// Valid/ready channel interfaces for the encoder event and result items.
// Depends on qegt_pkg.
interface qegt_in_if;
  logic             valid;
  logic             ready;
  qegt_pkg::item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface qegt_out_if;
  logic              valid;
  logic              ready;
  qegt_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/quadrature_encoder_gain_tuner_core.sv */
// Quadrature encoder gain tuner core: decoder state, gain table, result register.
// Depends on qegt_pkg and the interfaces in qegt_if.sv.
//
// Each item is a pin-A event from one encoder with its sampled A/B levels and
// the axis being tuned. The block decodes the encoder's transition history and,
// on a detent, steps one of nine gains (tenths, saturating at zero and at the
// top) and returns the new value; every item yields exactly one result item.
// From acceptance, an item is held in the input register, then decode and the
// saturating add settle into the result register. One item is accepted per
// cycle, limited only by the result side taking its items. The user must write
// step sizes through the cfg port only while idle; the block does not enforce it.
module quadrature_encoder_gain_tuner_core #(
  parameter int NUM_ENCODERS = 3,
  parameter int GAIN_BITS    = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [qegt_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [qegt_pkg::StepBits-1:0]   cfg_data_i,
  qegt_in_if.sink                         in_i,
  qegt_out_if.source                      out_o
);
  import qegt_pkg::*;

  localparam logic [GAIN_BITS:0] GainMax = {1'b0, {GAIN_BITS{1'b1}}};

  logic [StepBits-1:0]  fine_step_q, coarse_step_q;
  logic [CodeBits-1:0]  code_q [NUM_ENCODERS];
  logic [HistBits-1:0]  hist_q [NUM_ENCODERS];
  logic [GAIN_BITS-1:0] gain_q [NumGains];

  logic    in_vld_q, out_vld_q;
  item_t   in_q;
  result_t out_q, out_d;

  logic advance, fire, enc_ok, axis_ok, code_valid, up, down, detent;
  logic [CodeBits-1:0]  cur_code, new_code;
  logic [HistBits-1:0]  cur_hist, new_hist;
  logic [1:0]           term;
  logic [IndexBits-1:0] gidx;
  logic [GAIN_BITS-1:0] gain_rd, gain_new, step_ext;
  logic [GAIN_BITS:0]   gain_sum;
  logic [31:0]          gain_wide;

  assign advance  = !out_vld_q || out_o.ready;
  assign in_i.ready = !in_vld_q || advance;
  assign fire     = in_vld_q && advance;

  assign enc_ok  = (in_q.encoder < EncBits'(GainEncoders))
                && (int'(in_q.encoder) < NUM_ENCODERS);
  assign axis_ok = in_q.axis < AxisBits'(NumAxes);

  always_comb begin
    cur_code = '0;
    cur_hist = '0;
    for (int e = 0; e < NUM_ENCODERS; e++) begin
      if (int'(in_q.encoder) == e) begin
        cur_code = code_q[e];
        cur_hist = hist_q[e];
      end
    end
  end

  assign new_code   = {cur_code[1:0], in_q.level_a, in_q.level_b};
  assign code_valid = VALID_MASK[new_code];
  assign new_hist   = {cur_hist[3:0], new_code};
  assign up         = enc_ok && code_valid && (new_hist == HIST_UP);
  assign down       = enc_ok && code_valid && (new_hist == HIST_DOWN);
  assign detent     = up || down;

  assign term = 2'd2 - in_q.encoder;
  assign gidx = IndexBits'({in_q.axis, 1'b0}) + IndexBits'(in_q.axis) + IndexBits'(term);

  always_comb begin
    gain_rd = '0;
    for (int g = 0; g < NumGains; g++) begin
      if (gidx == IndexBits'(g)) gain_rd = gain_q[g];
    end
  end

  assign step_ext = GAIN_BITS'((in_q.encoder == ENC_COARSE) ? coarse_step_q : fine_step_q);
  assign gain_sum = {1'b0, gain_rd} + {1'b0, step_ext};

  always_comb begin
    if (up) begin
      gain_new = (gain_sum >= GainMax) ? GainMax[GAIN_BITS-1:0] : gain_sum[GAIN_BITS-1:0];
    end else if (gain_rd > step_ext) begin
      gain_new = gain_rd - step_ext;
    end else begin
      gain_new = '0;
    end
  end

  assign gain_wide = 32'(gain_new);

  always_comb begin
    out_d = '{movement: MOV_NONE, gain_index: '0, gain_value: '0};
    if (up)        out_d.movement = MOV_UP;
    else if (down) out_d.movement = MOV_DOWN;
    if (detent && axis_ok) begin
      out_d.gain_index = gidx;
      out_d.gain_value = gain_wide[ValueBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fine_step_q   <= StepBits'(1);
      coarse_step_q <= StepBits'(5);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FINE_STEP:   fine_step_q   <= cfg_data_i;
        CFG_COARSE_STEP: coarse_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) in_q <= in_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < NUM_ENCODERS; e++) begin
        code_q[e] <= '0;
        hist_q[e] <= '0;
      end
    end else if (fire && enc_ok) begin
      for (int e = 0; e < NUM_ENCODERS; e++) begin
        if (int'(in_q.encoder) == e) begin
          code_q[e] <= new_code;
          if (code_valid) hist_q[e] <= new_hist;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < NumGains; g++) gain_q[g] <= '0;
    end else if (fire && detent && axis_ok) begin
      for (int g = 0; g < NumGains; g++) begin
        if (gidx == IndexBits'(g)) gain_q[g] <= gain_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_q <= out_d;
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

`ifndef SYNTHESIS
  a_item_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("item in input register not moved to result register");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while both stages are full and stalled");

  a_no_detent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.movement == MOV_NONE) |->
      (out_q.gain_index == '0 && out_q.gain_value == '0))
    else $error("result without detent carries a gain");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.gain_index < IndexBits'(NumGains)))
    else $error("gain index out of range");

  a_bad_encoder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !enc_ok) |-> (!detent && !up && !down))
    else $error("detent on an encoder without a gain");
`endif

endmodule
